>>> sv/i2cs_pkg.sv
// Shared types and codes for the I2C master transaction sequencer.
// Holds request kinds, action codes, status flag positions and the item/result structs.
// No dependencies.
package i2cs_pkg;

	// request type codes as they arrive on req_type
	localparam logic [2:0] REQ_LOAD   = 3'd0;
	localparam logic [2:0] REQ_READ   = 3'd1;
	localparam logic [2:0] REQ_START  = 3'd2;
	localparam logic [2:0] REQ_STATUS = 3'd3;
	localparam logic [2:0] REQ_ERROR  = 3'd4;

	// classified kinds carried through the item queue
	localparam logic [2:0] K_LOAD   = 3'd0;
	localparam logic [2:0] K_READ   = 3'd1;
	localparam logic [2:0] K_START  = 3'd2;
	localparam logic [2:0] K_STATUS = 3'd3;
	localparam logic [2:0] K_ERROR  = 3'd4;

	// controller actions
	localparam logic [3:0] ACT_NONE   = 4'd0;
	localparam logic [3:0] ACT_WRITE  = 4'd1;
	localparam logic [3:0] ACT_START  = 4'd2;
	localparam logic [3:0] ACT_STOP   = 4'd3;
	localparam logic [3:0] ACT_ACK    = 4'd4;
	localparam logic [3:0] ACT_NACK   = 4'd5;
	localparam logic [3:0] ACT_DONE   = 4'd6;
	localparam logic [3:0] ACT_REJECT = 4'd7;
	localparam logic [3:0] ACT_REPLY  = 4'd8;
	localparam logic [3:0] ACT_CLR_AF = 4'd9;

	// status flag bit positions
	localparam int F_START_SENT = 0;
	localparam int F_ADDR_DONE  = 1;
	localparam int F_XMIT       = 2;
	localparam int F_TX_EMPTY   = 3;
	localparam int F_RX_FULL    = 4;
	localparam int F_BYTE_FIN   = 5;
	localparam int F_ACK_FAIL   = 6;

	localparam logic [5:0] POS_MAX = 6'h3F;

	localparam int IQ_DEPTH = 4;
	localparam int OQ_DEPTH = 2;

	typedef struct packed {
		logic [2:0] kind;
		logic [4:0] index;
		logic [7:0] byte_value;
		logic [6:0] dev_addr;
		logic       is_read;
		logic [5:0] byte_count;
		logic [6:0] status_flags;
	} item_t;

	typedef struct packed {
		logic [3:0] action;
		logic [7:0] action_value;
		logic       busy_res;
		logic       last_action;
	} res_t;

endpackage

>>> sv/i2cs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Width and depth are parameters; no dependencies.
module i2cs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                           clk,
	input  logic                                           we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
	input  logic [WIDTH-1:0]                               wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
	output logic [WIDTH-1:0]                               rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> sv/i2cs_fifo.sv
// Small show-ahead FIFO built from registers, used for the item and result queues.
// Width and depth are parameters; no dependencies.
module i2cs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end
endmodule

>>> sv/i2cs_front.sv
// Front end: accepts request beats, classifies them and queues the ones that matter.
// Depends on i2cs_pkg and i2cs_fifo.
module i2cs_front
	import i2cs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [2:0] req_type,
	input  logic [4:0] index,
	input  logic [7:0] byte_value,
	input  logic [6:0] dev_addr,
	input  logic       is_read,
	input  logic [5:0] byte_count,
	input  logic [6:0] status_flags,
	output item_t      item,
	output logic       item_valid,
	input  logic       item_pop
);
	item_t cls;
	logic  keep;
	logic  q_empty;

	always_comb begin
		cls.index        = index;
		cls.byte_value   = byte_value;
		cls.dev_addr     = dev_addr;
		cls.is_read      = is_read;
		cls.byte_count   = byte_count;
		cls.status_flags = status_flags;
		cls.kind         = K_LOAD;
		keep             = 1'b1;
		unique case (req_type)
			REQ_LOAD:   cls.kind = K_LOAD;
			REQ_READ:   cls.kind = K_READ;
			REQ_START:  cls.kind = K_START;
			REQ_STATUS: cls.kind = K_STATUS;
			REQ_ERROR: begin
				// only an ack failure does anything
				cls.kind = K_ERROR;
				keep     = status_flags[F_ACK_FAIL];
			end
			default:    keep = 1'b0;
		endcase
	end

	// dropped beats are still accepted, they just never enter the queue
	i2cs_fifo #(
		.WIDTH($bits(item_t)),
		.DEPTH(IQ_DEPTH)
	) u_iq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && keep),
		.wdata (cls),
		.full  (full),
		.pop   (item_pop),
		.rdata (item),
		.empty (q_empty)
	);

	assign item_valid = !q_empty;
endmodule

>>> sv/i2cs_back.sv
// Back end: sequencer that turns queued items into ordered controller actions.
// Owns the transaction state and the data buffer RAM. Depends on i2cs_pkg and i2cs_ram.
module i2cs_back
	import i2cs_pkg::*;
#(
	parameter int BUFFER_BYTES = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	input  item_t item,
	input  logic  item_valid,
	output logic  item_pop,
	output res_t  res,
	output logic  res_push,
	input  logic  out_full
);
	localparam int         AW    = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
	localparam logic [5:0] BUF_N = 6'(BUFFER_BYTES);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISP = 4'd1;
	localparam logic [3:0] S_ST2  = 4'd2;
	localparam logic [3:0] S_E2   = 4'd3;
	localparam logic [3:0] S_E3   = 4'd4;
	localparam logic [3:0] S_E4   = 4'd5;
	localparam logic [3:0] S_F0   = 4'd6;
	localparam logic [3:0] S_F1A  = 4'd7;
	localparam logic [3:0] S_F1B  = 4'd8;
	localparam logic [3:0] S_F3A  = 4'd9;
	localparam logic [3:0] S_F3B  = 4'd10;
	localparam logic [3:0] S_F3C  = 4'd11;
	localparam logic [3:0] S_F4   = 4'd12;
	localparam logic [3:0] S_F4B  = 4'd13;
	localparam logic [3:0] S_FIN  = 4'd14;

	logic [3:0] state_q, state_d;
	logic       busy_q, busy_d;
	logic [6:0] taddr_q, taddr_d;
	logic       rdir_q, rdir_d;
	logic [5:0] tcnt_q, tcnt_d;
	logic [5:0] pos_q, pos_d;
	item_t      item_q;
	res_t       pend_q;
	logic       pend_v_q;

	logic       step, emit, fin;
	logic [3:0] emit_act;
	logic [7:0] emit_val;
	logic       emit_busy;

	logic       ram_we;
	logic [5:0] ram_wa6, ram_ra6;
	logic [7:0] ram_rdata;

	logic [5:0] pos_inc, pos_new_m1;
	logic [6:0] left;
	logic       idx_ok, pos_ok;

	assign pos_inc    = (pos_q == POS_MAX) ? pos_q : pos_q + 6'd1;
	assign pos_new_m1 = pos_inc - 6'd1;
	assign left       = {1'b0, tcnt_q} - {1'b0, pos_inc};
	assign idx_ok     = {1'b0, item_q.index} < BUF_N;
	assign pos_ok     = pos_q < BUF_N;

	// outside idle the sequencer moves only while the result queue has room
	assign step = (state_q == S_IDLE) || !out_full;

	// outside idle the read address depends only on state and held registers, so a stall keeps rdata valid
	always_comb begin
		unique case (state_q)
			S_IDLE:       ram_ra6 = {1'b0, item.index};
			S_DISP:       ram_ra6 = {1'b0, item_q.index};
			S_F3A, S_F3B: ram_ra6 = pos_q;
			default:      ram_ra6 = '0;
		endcase
	end

	always_comb begin
		state_d   = state_q;
		busy_d    = busy_q;
		taddr_d   = taddr_q;
		rdir_d    = rdir_q;
		tcnt_d    = tcnt_q;
		pos_d     = pos_q;
		emit      = 1'b0;
		emit_act  = ACT_NONE;
		emit_val  = '0;
		emit_busy = busy_q;
		ram_we    = 1'b0;
		ram_wa6   = {1'b0, item_q.index};
		item_pop  = 1'b0;
		fin       = 1'b0;
		if (step) begin
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						item_pop = 1'b1;
						state_d  = S_DISP;
					end
				end
				S_DISP: begin
					unique case (item_q.kind)
						K_LOAD: begin
							ram_we  = !busy_q && idx_ok;
							state_d = S_FIN;
						end
						K_READ: begin
							emit     = 1'b1;
							emit_act = ACT_REPLY;
							emit_val = idx_ok ? ram_rdata : 8'd0;
							state_d  = S_FIN;
						end
						K_START: begin
							emit = 1'b1;
							if (busy_q || item_q.byte_count > BUF_N) begin
								emit_act = ACT_REJECT;
								state_d  = S_FIN;
							end else begin
								busy_d    = 1'b1;
								taddr_d   = item_q.dev_addr;
								rdir_d    = item_q.is_read;
								tcnt_d    = item_q.byte_count;
								pos_d     = '0;
								emit_act  = ACT_ACK;
								emit_busy = 1'b1;
								state_d   = S_ST2;
							end
						end
						K_ERROR: begin
							emit     = 1'b1;
							emit_act = ACT_CLR_AF;
							state_d  = S_E2;
						end
						default: state_d = S_F0;
					endcase
				end
				S_ST2: begin
					emit     = 1'b1;
					emit_act = ACT_START;
					state_d  = S_FIN;
				end
				S_E2: begin
					emit     = 1'b1;
					emit_act = ACT_STOP;
					state_d  = S_E3;
				end
				S_E3: begin
					busy_d    = 1'b0;
					emit      = 1'b1;
					emit_act  = ACT_ACK;
					emit_busy = 1'b0;
					state_d   = S_E4;
				end
				S_E4: begin
					emit     = 1'b1;
					emit_act = ACT_START;
					state_d  = S_FIN;
				end
				S_F0: begin
					if (item_q.status_flags[F_START_SENT]) begin
						emit     = 1'b1;
						emit_act = ACT_WRITE;
						emit_val = {taddr_q, rdir_q};
					end
					state_d = S_F1A;
				end
				S_F1A: begin
					if (item_q.status_flags[F_ADDR_DONE] && rdir_q && tcnt_q == 6'd1) begin
						emit     = 1'b1;
						emit_act = ACT_NACK;
					end
					state_d = S_F1B;
				end
				S_F1B: begin
					if (item_q.status_flags[F_ADDR_DONE]) begin
						if (item_q.status_flags[F_XMIT]) begin
							// first data byte goes out right behind the address
							emit     = 1'b1;
							emit_act = ACT_WRITE;
							emit_val = ram_rdata;
							pos_d    = pos_inc;
						end else if (tcnt_q == 6'd1) begin
							emit     = 1'b1;
							emit_act = ACT_STOP;
						end
					end
					state_d = S_F3A;
				end
				S_F3A: state_d = S_F3B;
				S_F3B: begin
					state_d = S_F4;
					if (item_q.status_flags[F_TX_EMPTY]) begin
						if (pos_q < tcnt_q) begin
							emit     = 1'b1;
							emit_act = ACT_WRITE;
							emit_val = pos_ok ? ram_rdata : 8'd0;
							pos_d    = pos_inc;
						end else if (item_q.status_flags[F_BYTE_FIN]) begin
							emit     = 1'b1;
							emit_act = ACT_STOP;
							state_d  = S_F3C;
						end
					end
				end
				S_F3C: begin
					busy_d    = 1'b0;
					emit      = 1'b1;
					emit_act  = ACT_DONE;
					emit_busy = 1'b0;
					state_d   = S_F4;
				end
				S_F4: begin
					state_d = S_FIN;
					if (item_q.status_flags[F_RX_FULL]) begin
						pos_d   = pos_inc;
						ram_wa6 = pos_new_m1;
						ram_we  = pos_new_m1 < BUF_N;
						if (left == 7'd1) begin
							emit     = 1'b1;
							emit_act = ACT_NACK;
							state_d  = S_F4B;
						end else if (left == 7'd0) begin
							busy_d    = 1'b0;
							emit      = 1'b1;
							emit_act  = ACT_DONE;
							emit_busy = 1'b0;
						end
					end
				end
				S_F4B: begin
					emit     = 1'b1;
					emit_act = ACT_STOP;
					state_d  = S_FIN;
				end
				S_FIN: begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end
				default: state_d = S_IDLE;
			endcase
		end
	end

	// hold each action until the next one or the end of the item so the last one of an item can be marked
	assign res_push = pend_v_q && (emit || fin);
	always_comb begin
		res             = pend_q;
		res.last_action = fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			busy_q   <= 1'b0;
			taddr_q  <= '0;
			rdir_q   <= 1'b0;
			tcnt_q   <= '0;
			pos_q    <= '0;
			pend_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= busy_d;
			taddr_q <= taddr_d;
			rdir_q  <= rdir_d;
			tcnt_q  <= tcnt_d;
			pos_q   <= pos_d;
			if (emit) begin
				pend_v_q <= 1'b1;
			end else if (fin) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			item_q <= item;
		end
		if (emit) begin
			pend_q.action       <= emit_act;
			pend_q.action_value <= emit_val;
			pend_q.busy_res     <= emit_busy;
			pend_q.last_action  <= 1'b0;
		end
	end

	i2cs_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_BYTES)
	) u_buf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_wa6[AW-1:0]),
		.wdata(item_q.byte_value),
		.raddr(ram_ra6[AW-1:0]),
		.rdata(ram_rdata)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !out_full)
		else $error("result pushed into a full queue");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |-> (state_q == S_IDLE && item_valid))
		else $error("item taken outside idle or from an empty queue");

	a_pend_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_v_q)
		else $error("held action left over at idle");

	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> ($past(state_q) == S_F3C || $past(state_q) == S_F4
			|| $past(state_q) == S_E3))
		else $error("busy dropped outside a done or error step");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.last_action) |=> state_q == S_IDLE)
		else $error("last action pushed without returning to idle");
endmodule

>>> sv/i2c_master_transaction_sequencer_unit.sv
// I2C master transaction sequencer, top level. Depends on i2cs_pkg, i2cs_front, i2cs_back, i2cs_fifo.
// The sequencer takes an item from the item queue only when idle and works through it one step per
// cycle while the result queue has room; a 4-beat item queue and a 2-beat result queue absorb stalls.
// Reset (arst_n low) clears state and both queues; the buffer is not cleared.
module i2c_master_transaction_sequencer_unit
	import i2cs_pkg::*;
#(
	parameter int BUFFER_BYTES = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [2:0] req_type,
	input  logic [4:0] index,
	input  logic [7:0] byte_value,
	input  logic [6:0] dev_addr,
	input  logic       is_read,
	input  logic [5:0] byte_count,
	input  logic [6:0] status_flags,
	output logic       empty,
	input  logic       pop,
	output logic [3:0] action,
	output logic [7:0] action_value,
	output logic       busy_res,
	output logic       last_action
);
	item_t item;
	logic  item_valid, item_pop;
	res_t  res_in, res_out;
	logic  res_push, out_full;

	i2cs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.req_type    (req_type),
		.index       (index),
		.byte_value  (byte_value),
		.dev_addr    (dev_addr),
		.is_read     (is_read),
		.byte_count  (byte_count),
		.status_flags(status_flags),
		.item        (item),
		.item_valid  (item_valid),
		.item_pop    (item_pop)
	);

	i2cs_back #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.item_valid(item_valid),
		.item_pop  (item_pop),
		.res       (res_in),
		.res_push  (res_push),
		.out_full  (out_full)
	);

	i2cs_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(OQ_DEPTH)
	) u_oq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (out_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign action       = res_out.action;
	assign action_value = res_out.action_value;
	assign busy_res     = res_out.busy_res;
	assign last_action  = res_out.last_action;
endmodule

>>> tb/tb_i2c_master_transaction_sequencer_unit.sv
// Testbench for the I2C master transaction sequencer: directed and random request beats
// against an in-bench model of the action sequence, checked beat by beat on the result side.
// Depends on i2cs_pkg and i2c_master_transaction_sequencer_unit.
`timescale 1ns / 100ps

module tb_i2c_master_transaction_sequencer_unit;
	import i2cs_pkg::*;

	localparam int BUF_BYTES = 32;
	localparam int ITEM_GOAL = 450;
	localparam int IDLE_PCT  = 36;
	localparam int SETTLE_CYCLES = 24;
	localparam int MAX_PRINTED = 100;

	localparam logic [6:0] M_START_SENT = 7'(1) << F_START_SENT;
	localparam logic [6:0] M_ADDR_DONE  = 7'(1) << F_ADDR_DONE;
	localparam logic [6:0] M_XMIT       = 7'(1) << F_XMIT;
	localparam logic [6:0] M_TX_EMPTY   = 7'(1) << F_TX_EMPTY;
	localparam logic [6:0] M_RX_FULL    = 7'(1) << F_RX_FULL;
	localparam logic [6:0] M_BYTE_FIN   = 7'(1) << F_BYTE_FIN;
	localparam logic [6:0] M_ACK_FAIL   = 7'(1) << F_ACK_FAIL;

	// state copies: 0 tracks the generated stream, 1 tracks accepted beats, 2 is scratch
	localparam int GEN = 0;
	localparam int CHK = 1;
	localparam int TRY = 2;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [2:0] req_type = '0;
	logic [4:0] index = '0;
	logic [7:0] byte_value = '0;
	logic [6:0] dev_addr = '0;
	logic       is_read = 1'b0;
	logic [5:0] byte_count = '0;
	logic [6:0] status_flags = '0;
	logic       empty;
	logic       pop = 1'b0;
	logic [3:0] action;
	logic [7:0] action_value;
	logic       busy_res;
	logic       last_action;

	i2c_master_transaction_sequencer_unit #(
		.BUFFER_BYTES(BUF_BYTES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req_type(req_type),
		.index(index),
		.byte_value(byte_value),
		.dev_addr(dev_addr),
		.is_read(is_read),
		.byte_count(byte_count),
		.status_flags(status_flags),
		.empty(empty),
		.pop(pop),
		.action(action),
		.action_value(action_value),
		.busy_res(busy_res),
		.last_action(last_action)
	);

	always #10 clk = ~clk;

	logic [7:0] mem_byte [3][BUF_BYTES];
	bit         mem_set [3][BUF_BYTES];
	bit         xfer_busy [3];
	logic [6:0] xfer_addr [3];
	bit         xfer_dir [3];
	logic [5:0] xfer_count [3];
	logic [5:0] xfer_pos [3];

	res_t  seq_out [$];
	bit    blank_read;
	item_t outgoing_reqs [$];
	item_t taken_reqs [$];
	res_t  due_actions [$];
	item_t cur_req;
	int    items_taken = 0;
	int    mismatches = 0;
	int    counted_items = 0;
	bit    steady;

	// long stretch without idling on either side
	assign steady = (items_taken >= 150) && (items_taken < 320);

	function automatic void clear_state(int s);
		for (int i = 0; i < BUF_BYTES; i++) begin
			mem_byte[s][i] = '0;
			mem_set[s][i] = 1'b0;
		end
		xfer_busy[s] = 1'b0;
		xfer_addr[s] = '0;
		xfer_dir[s] = 1'b0;
		xfer_count[s] = '0;
		xfer_pos[s] = '0;
	endfunction

	function automatic void copy_state(int d, int s);
		for (int i = 0; i < BUF_BYTES; i++) begin
			mem_byte[d][i] = mem_byte[s][i];
			mem_set[d][i] = mem_set[s][i];
		end
		xfer_busy[d] = xfer_busy[s];
		xfer_addr[d] = xfer_addr[s];
		xfer_dir[d] = xfer_dir[s];
		xfer_count[d] = xfer_count[s];
		xfer_pos[d] = xfer_pos[s];
	endfunction

	function automatic logic [7:0] fetch_byte(int s, logic [5:0] p);
		if (p < BUF_BYTES) begin
			if (!mem_set[s][p])
				blank_read = 1'b1;
			return mem_byte[s][p];
		end
		return 8'h00;
	endfunction

	function automatic void add_action(int s, logic [3:0] a, logic [7:0] v);
		res_t r;
		r.action = a;
		r.action_value = v;
		r.busy_res = xfer_busy[s];
		r.last_action = 1'b0;
		seq_out.push_back(r);
	endfunction

	function automatic void advance_pos(int s);
		if (xfer_pos[s] != POS_MAX)
			xfer_pos[s] = xfer_pos[s] + 6'd1;
	endfunction

	// actions that one request beat causes, in order, with state update
	function automatic void next_actions(int s, item_t it);
		res_t r;
		int   wp;
		int   left;
		seq_out.delete();
		blank_read = 1'b0;
		case (it.kind)
			REQ_LOAD: begin
				if (!xfer_busy[s] && it.index < BUF_BYTES) begin
					mem_byte[s][it.index] = it.byte_value;
					mem_set[s][it.index] = 1'b1;
				end
			end
			REQ_READ: add_action(s, ACT_REPLY, fetch_byte(s, {1'b0, it.index}));
			REQ_START: begin
				if (xfer_busy[s] || it.byte_count > BUF_BYTES) begin
					add_action(s, ACT_REJECT, 8'h00);
				end else begin
					xfer_busy[s] = 1'b1;
					xfer_addr[s] = it.dev_addr;
					xfer_dir[s] = it.is_read;
					xfer_count[s] = it.byte_count;
					xfer_pos[s] = '0;
					add_action(s, ACT_ACK, 8'h00);
					add_action(s, ACT_START, 8'h00);
				end
			end
			REQ_STATUS: begin
				if (it.status_flags[F_START_SENT])
					add_action(s, ACT_WRITE, {xfer_addr[s], xfer_dir[s]});
				if (it.status_flags[F_ADDR_DONE]) begin
					if (xfer_dir[s] && xfer_count[s] == 6'd1)
						add_action(s, ACT_NACK, 8'h00);
					if (it.status_flags[F_XMIT]) begin
						add_action(s, ACT_WRITE, fetch_byte(s, 6'd0));
						advance_pos(s);
					end else if (xfer_count[s] == 6'd1) begin
						add_action(s, ACT_STOP, 8'h00);
					end
				end
				if (it.status_flags[F_TX_EMPTY]) begin
					if (xfer_pos[s] < xfer_count[s]) begin
						add_action(s, ACT_WRITE, fetch_byte(s, xfer_pos[s]));
						advance_pos(s);
					end else if (it.status_flags[F_BYTE_FIN]) begin
						add_action(s, ACT_STOP, 8'h00);
						xfer_busy[s] = 1'b0;
						add_action(s, ACT_DONE, 8'h00);
					end
				end
				if (it.status_flags[F_RX_FULL]) begin
					advance_pos(s);
					wp = int'(xfer_pos[s]) - 1;
					if (wp >= 0 && wp < BUF_BYTES) begin
						mem_byte[s][wp] = it.byte_value;
						mem_set[s][wp] = 1'b1;
					end
					left = int'(xfer_count[s]) - int'(xfer_pos[s]);
					if (left == 1) begin
						add_action(s, ACT_NACK, 8'h00);
						add_action(s, ACT_STOP, 8'h00);
					end else if (left == 0) begin
						xfer_busy[s] = 1'b0;
						add_action(s, ACT_DONE, 8'h00);
					end
				end
			end
			REQ_ERROR: begin
				if (it.status_flags[F_ACK_FAIL]) begin
					add_action(s, ACT_CLR_AF, 8'h00);
					add_action(s, ACT_STOP, 8'h00);
					xfer_busy[s] = 1'b0;
					add_action(s, ACT_ACK, 8'h00);
					add_action(s, ACT_START, 8'h00);
				end
			end
			default: ;
		endcase
		if (seq_out.size() > 0) begin
			r = seq_out.pop_back();
			r.last_action = 1'b1;
			seq_out.push_back(r);
		end
	endfunction

	function automatic item_t make_req(logic [2:0] k, logic [4:0] idx, logic [7:0] v,
			logic [6:0] a, bit rd, logic [5:0] n, logic [6:0] fl);
		item_t it;
		it.kind = k;
		it.index = idx;
		it.byte_value = v;
		it.dev_addr = a;
		it.is_read = rd;
		it.byte_count = n;
		it.status_flags = fl;
		return it;
	endfunction

	// queue a beat unless it would read a buffer entry that was never written
	function automatic void offer(item_t it);
		copy_state(TRY, GEN);
		next_actions(TRY, it);
		if (!blank_read) begin
			copy_state(GEN, TRY);
			outgoing_reqs.push_back(it);
			if (it.kind <= REQ_ERROR)
				counted_items++;
		end
	endfunction

	function automatic void offer_status(logic [6:0] fl, logic [7:0] v);
		offer(make_req(REQ_STATUS, 5'($urandom), v, 7'($urandom), 1'($urandom),
			6'($urandom), fl));
	endfunction

	function automatic void drop_transfer();
		if (xfer_busy[GEN])
			offer(make_req(REQ_ERROR, '0, 8'($urandom), '0, 1'b0, '0,
				7'($urandom) | M_ACK_FAIL));
	endfunction

	function automatic int pick_count();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return 0;
		if (r < 85)
			return $urandom_range(6, 1);
		return $urandom_range(BUF_BYTES, 7);
	endfunction

	function automatic void write_transfer(int n);
		drop_transfer();
		for (int i = 0; i < n || i == 0; i++)
			offer(make_req(REQ_LOAD, 5'(i), 8'($urandom), '0, 1'b0, '0, '0));
		offer(make_req(REQ_START, '0, '0, 7'($urandom), 1'b0, 6'(n), '0));
		offer_status(M_START_SENT, 8'($urandom));
		offer_status(M_ADDR_DONE | M_XMIT, 8'($urandom));
		for (int k = 1; k < n; k++) begin
			if ($urandom_range(15) == 0) begin
				drop_transfer();
				return;
			end
			offer_status(M_TX_EMPTY | M_XMIT, 8'($urandom));
		end
		offer_status(M_TX_EMPTY | M_BYTE_FIN | M_XMIT, 8'($urandom));
	endfunction

	function automatic void read_transfer(int n);
		drop_transfer();
		offer(make_req(REQ_START, '0, '0, 7'($urandom), 1'b1, 6'(n), '0));
		offer_status(M_START_SENT, 8'($urandom));
		offer_status(M_ADDR_DONE, 8'($urandom));
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(15) == 0) begin
				drop_transfer();
				return;
			end
			offer_status(M_RX_FULL, 8'($urandom));
		end
		for (int k = 0; k < n && k < 3; k++)
			offer(make_req(REQ_READ, 5'($urandom_range(n - 1)), '0, '0, 1'b0, '0, '0));
	endfunction

	function automatic void noise_burst();
		int n;
		n = $urandom_range(4, 1);
		for (int i = 0; i < n; i++)
			offer(make_req(3'($urandom), 5'($urandom), 8'($urandom), 7'($urandom),
				1'($urandom), 6'($urandom), 7'($urandom)));
	endfunction

	task automatic flag_mismatch(string what);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("%0t mismatch: %s", $realtime, what);
	endtask

	// stimulus
	initial begin
		bit drifted;
		int r;
		drifted = 1'b0;
		clear_state(GEN);
		clear_state(CHK);

		offer(make_req(REQ_LOAD, 5'd0, 8'hA5, '0, 1'b0, '0, '0));
		offer(make_req(REQ_LOAD, 5'd31, 8'hFF, '0, 1'b0, '0, '0));
		offer(make_req(REQ_LOAD, 5'd1, 8'h00, '0, 1'b0, '0, '0));
		offer(make_req(REQ_READ, 5'd31, '0, '0, 1'b0, '0, '0));
		offer(make_req(REQ_READ, 5'd0, '0, '0, 1'b0, '0, '0));
		offer(make_req(REQ_START, '0, '0, 7'h7F, 1'b0, 6'd33, '0));
		offer(make_req(REQ_START, '0, '0, 7'h7F, 1'b0, 6'd2, '0));
		offer(make_req(REQ_START, '0, '0, 7'h12, 1'b1, 6'd1, '0));
		offer(make_req(REQ_LOAD, 5'd1, 8'h33, '0, 1'b0, '0, '0));
		offer_status(M_START_SENT, 8'h00);
		offer_status(M_ADDR_DONE | M_XMIT, 8'h00);
		offer_status(M_TX_EMPTY, 8'h00);
		offer_status(M_TX_EMPTY | M_BYTE_FIN, 8'h00);
		offer_status(7'h00, 8'hFF);
		offer_status(M_ACK_FAIL, 8'hFF);
		offer(make_req(REQ_ERROR, '0, '0, '0, 1'b0, '0, 7'h3F));
		for (int k = 1; k <= 3; k++)
			offer(make_req(3'(REQ_ERROR + k), 5'h1F, 8'hFF, 7'h7F, 1'b1, 6'h3F, 7'h7F));
		offer(make_req(REQ_START, '0, '0, 7'h00, 1'b1, 6'd1, '0));
		offer_status(M_ADDR_DONE, 8'h00);
		offer_status(M_RX_FULL, 8'h5A);
		offer(make_req(REQ_ERROR, '0, '0, '0, 1'b0, '0, 7'h7F));
		offer(make_req(REQ_START, '0, '0, 7'h55, 1'b0, 6'd0, '0));
		offer_status(7'h7F, 8'hC3);

		while (counted_items < ITEM_GOAL) begin
			r = $urandom_range(99);
			if (r < 40)
				write_transfer(pick_count());
			else if (r < 78)
				read_transfer(pick_count() > 0 ? pick_count() : 1);
			else
				noise_burst();
			// overrun a full-size read so the position saturates
			if (!drifted && counted_items > 200) begin
				drifted = 1'b1;
				drop_transfer();
				offer(make_req(REQ_START, '0, '0, 7'($urandom), 1'b1, 6'(BUF_BYTES), '0));
				for (int k = 0; k < 66; k++)
					offer_status(M_RX_FULL, 8'($urandom));
				drop_transfer();
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (outgoing_reqs.size() != 0 || push)
			@(posedge clk);
		while (taken_reqs.size() != 0 || due_actions.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin : drive_reqs
		bit    go;
		item_t nxt;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			go = push;
			if (push && !full) begin
				taken_reqs.push_back(cur_req);
				items_taken++;
				go = 1'b0;
			end
			if (!go && outgoing_reqs.size() > 0 &&
					(steady || $urandom_range(99) >= IDLE_PCT)) begin
				nxt = outgoing_reqs.pop_front();
				cur_req = nxt;
				req_type <= nxt.kind;
				index <= nxt.index;
				byte_value <= nxt.byte_value;
				dev_addr <= nxt.dev_addr;
				is_read <= nxt.is_read;
				byte_count <= nxt.byte_count;
				status_flags <= nxt.status_flags;
				go = 1'b1;
			end
			push <= go;
		end
	end

	// turn accepted beats into expected actions between rising edges
	always @(negedge clk) begin
		while (taken_reqs.size() > 0) begin
			next_actions(CHK, taken_reqs.pop_front());
			foreach (seq_out[i])
				due_actions.push_back(seq_out[i]);
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin : watch_actions
		res_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (due_actions.size() == 0) begin
					flag_mismatch($sformatf("unexpected action %0d value %02h",
						action, action_value));
				end else begin
					want = due_actions.pop_front();
					if (action !== want.action)
						flag_mismatch($sformatf("action %0d, want %0d",
							action, want.action));
					if (action_value !== want.action_value)
						flag_mismatch($sformatf("action_value %02h, want %02h (action %0d)",
							action_value, want.action_value, want.action));
					if (busy_res !== want.busy_res)
						flag_mismatch($sformatf("busy_res %b, want %b (action %0d)",
							busy_res, want.busy_res, want.action));
					if (last_action !== want.last_action)
						flag_mismatch($sformatf("last_action %b, want %b (action %0d)",
							last_action, want.last_action, want.action));
				end
			end
			pop <= steady || $urandom_range(99) >= IDLE_PCT;
		end
	end

endmodule
